// File: rtl/core/gwm_pkg.sv
package gwm_pkg;

	localparam int PATTERN_MAX_DEF = 32;

	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_DOT      = 8'h2E;

	typedef enum logic {
		ACT_PATTERN = 1'b0,
		ACT_NAME    = 1'b1
	} gwm_action_t;

	// one accepted input beat as seen by the cell row
	typedef struct packed {
		logic       pat_beat;
		logic       name_beat;
		logic       first;
		logic [7:0] ch;
	} gwm_ctl_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} gwm_res_t;

endpackage

// File: rtl/core/gwm_if.sv
interface gwm_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] char_in;
	logic       first;
	logic       last;

	modport source (output valid, action, char_in, first, last, input ready);
	modport sink (input valid, action, char_in, first, last, output ready);
endinterface

interface gwm_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, matched, pattern_overflow, input ready);
	modport sink (input valid, matched, pattern_overflow, output ready);
endinterface

interface gwm_cfg_if;
	logic valid;
	logic ready;
	logic hide_dot_names;

	modport source (output valid, hide_dot_names, input ready);
	modport sink (input valid, hide_dot_names, output ready);
endinterface

// File: rtl/core/glob_wildcard_matcher.sv
// Shell-style wildcard matcher ('*' any run, '?' any one byte).
// item: one byte per beat. action selects pattern load or name match;
//   first starts a new pattern or name, last marks the final name byte.
// result: one beat per name, after the beat with last set, carrying
//   matched and pattern_overflow. Pattern beats give no result.
// cfg: writes hide_dot_names; always ready, write only while idle.
// Unstalled throughput is one item per cycle: every position has its own
//   cell, and all cells update in parallel with a star closure in one add.
// Latency: the result is valid the cycle after the last name byte is taken.
// A pending result sits in the output register; item keeps flowing while
//   result is taken, and item.ready drops only while a result waits and
//   result.ready is low.
// Reset: no pattern stored, no active positions, hide_dot_names = 1,
//   result channel empty. Bytes beyond PATTERN_MAX set pattern_overflow.
module glob_wildcard_matcher #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
	input logic          clk,
	input logic          arst_n,
	gwm_item_if.sink     item,
	gwm_result_if.source result,
	gwm_cfg_if.sink      cfg
);
	import gwm_pkg::*;

	logic     hide_q;
	logic     out_valid_q;
	logic     matched_q;
	logic     ovf_q;
	logic     accept;
	logic     is_name;
	gwm_ctl_t ctl;
	gwm_res_t res;

	assign cfg.ready  = 1'b1;
	assign item.ready = ~out_valid_q | result.ready;
	assign accept     = item.valid & item.ready;
	assign is_name    = (gwm_action_t'(item.action) == ACT_NAME);

	assign ctl.pat_beat  = accept & ~is_name;
	assign ctl.name_beat = accept & is_name;
	assign ctl.first     = item.first;
	assign ctl.ch        = item.char_in;

	gwm_row #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.hide_dot (hide_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hide_q <= 1'b1;
		end else if (cfg.valid) begin
			hide_q <= cfg.hide_dot_names;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.name_beat && item.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.name_beat && item.last) begin
			matched_q <= res.matched;
			ovf_q     <= res.overflow;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.matched          = matched_q;
	assign result.pattern_overflow = ovf_q;

endmodule

// File: rtl/core/gwm_cell.sv
module gwm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  gwm_pkg::gwm_ctl_t ctl,
	input  logic              wr_en,
	input  logic              start_bit,
	input  logic              act_d,
	output logic              stay,
	output logic              hop,
	output logic              star
);
	import gwm_pkg::*;

	logic [7:0] pat_q;
	logic       used_q;
	logic       act_q;
	logic       cur;
	logic       is_star;
	logic       hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= ctl.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= 1'b0;
		end else if (ctl.pat_beat) begin
			// a new pattern drops every cell but the one written now
			used_q <= wr_en | (used_q & ~ctl.first);
			act_q  <= 1'b0;
		end else if (ctl.name_beat) begin
			act_q <= act_d;
		end
	end

	// a new name starts from the precomputed leading-star closure
	assign cur     = ctl.first ? start_bit : act_q;
	assign is_star = used_q & (pat_q == CH_STAR);
	assign hit     = (pat_q == CH_QUESTION) | (pat_q == ctl.ch);

	assign star = is_star;
	assign stay = cur & is_star;
	assign hop  = cur & used_q & ~is_star & hit;

endmodule

// File: rtl/core/gwm_row.sv
module gwm_row #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gwm_pkg::gwm_ctl_t ctl,
	input  logic              hide_dot,
	output gwm_pkg::gwm_res_t res
);
	import gwm_pkg::*;

	localparam int N  = PATTERN_MAX;
	localparam int LW = $clog2(N + 1);

	logic [N-1:0]  stay;
	logic [N-1:0]  hop;
	logic [N-1:0]  star;
	logic [N-1:0]  wr_en;
	logic [N:0]    raw;
	logic [N:0]    smask;
	logic [N:0]    fill;
	logic [N:0]    closed;
	logic [N:0]    start_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] widx;
	logic          ovf_q;
	logic          dot_q;
	logic          hidden_q;
	logic          hidden_now;
	logic          ch_star;
	logic          ch_dot;

	assign ch_star = (ctl.ch == CH_STAR);
	assign ch_dot  = (ctl.ch == CH_DOT);
	assign widx    = ctl.first ? '0 : len_q;

	for (genvar i = 0; i < N; i++) begin : g_cell
		assign wr_en[i] = ctl.pat_beat & (widx == LW'(i));

		gwm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.wr_en     (wr_en[i]),
			.start_bit (start_q[i]),
			.act_d     (closed[i]),
			.stay      (stay[i]),
			.hop       (hop[i]),
			.star      (star[i])
		);
	end

	// star runs behave like carry propagation: the add spreads a set bit
	// through a run of stars up to the first non-star position
	assign raw    = {hop, 1'b0} | {1'b0, stay};
	assign smask  = {1'b0, star};
	assign fill   = ((raw & smask) + smask) ^ smask;
	assign closed = raw | fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			start_q  <= (N + 1)'(1);
			ovf_q    <= 1'b0;
			dot_q    <= 1'b0;
			hidden_q <= 1'b0;
		end else if (ctl.pat_beat) begin
			if (ctl.first) begin
				len_q   <= LW'(1);
				ovf_q   <= 1'b0;
				dot_q   <= ch_dot;
				start_q <= (N + 1)'(1) | (ch_star ? (N + 1)'(2) : '0);
			end else if (len_q != LW'(N)) begin
				// a pattern loaded without first still starts at position zero
				if (len_q == '0) begin
					dot_q <= ch_dot;
				end
				len_q                   <= len_q + LW'(1);
				start_q[len_q + LW'(1)] <= start_q[len_q] & ch_star;
			end else begin
				ovf_q <= 1'b1;
			end
		end else if (ctl.name_beat && ctl.first) begin
			hidden_q <= ch_dot;
		end
	end

	assign hidden_now = ctl.first ? ch_dot : hidden_q;

	assign res.matched  = closed[len_q] & ~ovf_q & ~(hide_dot & hidden_now & ~dot_q);
	assign res.overflow = ovf_q;

endmodule

// File: rtl/core/gwm_checker.sv
module gwm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_action,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_matched,
	input logic out_overflow
);
	import gwm_pkg::*;

	logic last_beat;

	assign last_beat = in_valid & in_ready & (gwm_action_t'(in_action) == ACT_NAME) & in_last;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_matched) && $stable(out_overflow))
		else $error("result payload changed while stalled");

	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_matched && out_overflow))
		else $error("match reported with overflowed pattern");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		last_beat |=> out_valid)
		else $error("no result after last name byte");

	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(last_beat))
		else $error("result without a last name byte");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.in_action    (item.action),
	.in_last      (item.last),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_matched  (result.matched),
	.out_overflow (result.pattern_overflow)
);
